// File: rtl/csec_pkg.sv
// shared types, constants and angle tables for the complex secant unit
// used by every module under rtl/, depends on nothing else
package csec_pkg;

  localparam int unsigned CORDIC_STAGES = 24;
  localparam int unsigned DIV_STEPS     = 32;

  // datapath widths
  localparam int unsigned CW  = 34;  // circular x/y
  localparam int unsigned HW  = 36;  // hyperbolic x/y
  localparam int unsigned ZW  = 34;  // angle accumulators
  localparam int unsigned PW  = 46;  // multiplier operands
  localparam int unsigned LOW = 30;  // low part of a split operand
  localparam int unsigned MW  = 64;  // products and denominator
  localparam int unsigned RW  = 80;  // divider remainder
  localparam int unsigned DCW = 96;  // divider compare width

  localparam logic [39:0] TWO_PI_Q  = 40'd6746518852;
  localparam logic [39:0] PI_Q      = 40'd3373259426;
  localparam logic [39:0] HALF_PI_Q = 40'd1686629713;
  localparam logic [33:0] LN2_Q     = 34'd744261118;
  localparam logic signed [CW-1:0] CIRC_GAIN = 34'sd652032874;
  localparam logic signed [HW-1:0] HYP_GAIN  = 36'sd889229343;
  localparam logic signed [PW-1:0] ONE_Q     = 46'sd1073741824;
  localparam logic signed [23:0]   B_LIMIT   = 24'sd524288;
  localparam logic signed [40:0]   V_OFFSET  = 41'sd215888603264;  // 32 * 2pi

  localparam logic signed [ZW-1:0] ATAN_TAB [10] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
    34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149
  };

  localparam logic signed [ZW-1:0] ATANH_TAB [10] = '{
    34'sd0, 34'sd589812981, 34'sd274247419, 34'sd134923406, 34'sd67196451,
    34'sd33565361, 34'sd16778581, 34'sd8388779, 34'sd4194325, 34'sd2097155
  };

  typedef struct packed {
    logic signed [23:0] real_part;
    logic signed [23:0] imag_part;
  } csec_in_t;

  typedef struct packed {
    logic signed [31:0] real_result;
    logic signed [31:0] imag_result;
    logic               pole_flag;
    logic               saturated_flag;
  } csec_out_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } csec_circ_t;

  typedef struct packed {
    logic signed [HW-1:0] x;
    logic signed [HW-1:0] y;
    logic signed [ZW-1:0] z;
  } csec_hyp_t;

  typedef struct packed {
    logic [RW-1:0] rem_re;
    logic [RW-1:0] rem_im;
    logic [MW-1:0] den;
    logic [31:0]   q_re;
    logic [31:0]   q_im;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
    logic          pole;
  } csec_div_t;

  function automatic logic signed [ZW-1:0] circ_angle(input int i);
    logic signed [ZW-1:0] a;
    a = '0;
    if (i < 10) begin
      a = ATAN_TAB[i];
    end else if (i <= 30) begin
      a = ZW'(1) << (30 - i);
    end
    return a;
  endfunction

  function automatic logic signed [ZW-1:0] hyp_angle(input int j);
    logic signed [ZW-1:0] a;
    a = '0;
    if (j < 10) begin
      a = ATANH_TAB[j];
    end else if (j <= 30) begin
      a = ZW'(1) << (30 - j);
    end
    return a;
  endfunction

  // shift of hyperbolic step i, with the repeats at 4, 13, 40
  function automatic int hyp_shift(input int i);
    int   j;
    int   rep;
    int   t;
    logic again;
    j     = 1;
    rep   = 4;
    again = 1'b0;
    for (t = 0; t < i; t++) begin
      if (j == rep && !again) begin
        again = 1'b1;
      end else begin
        if (again) begin
          again = 1'b0;
          rep   = 3 * rep + 1;
        end
        j++;
      end
    end
    return j;
  endfunction

endpackage

// File: rtl/csec_circ_cell.sv
// one circular cordic rotation step with its output register
// depends on csec_pkg
module csec_circ_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk_i,
  input  csec_pkg::csec_circ_t cell_i,
  output csec_pkg::csec_circ_t cell_o
);

  localparam logic signed [csec_pkg::ZW-1:0] ANG = csec_pkg::circ_angle(STAGE);

  csec_pkg::csec_circ_t cell_d, cell_q;

  always_comb begin
    if (!cell_i.z[csec_pkg::ZW-1]) begin
      cell_d.x = cell_i.x - (cell_i.y >>> STAGE);
      cell_d.y = cell_i.y + (cell_i.x >>> STAGE);
      cell_d.z = cell_i.z - ANG;
    end else begin
      cell_d.x = cell_i.x + (cell_i.y >>> STAGE);
      cell_d.y = cell_i.y - (cell_i.x >>> STAGE);
      cell_d.z = cell_i.z + ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/csec_hyp_cell.sv
// one hyperbolic cordic step with its output register
// depends on csec_pkg
module csec_hyp_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                clk_i,
  input  csec_pkg::csec_hyp_t cell_i,
  output csec_pkg::csec_hyp_t cell_o
);

  localparam int unsigned SHIFT = csec_pkg::hyp_shift(STAGE);
  localparam logic signed [csec_pkg::ZW-1:0] ANG = csec_pkg::hyp_angle(SHIFT);

  csec_pkg::csec_hyp_t cell_d, cell_q;

  always_comb begin
    if (!cell_i.z[csec_pkg::ZW-1]) begin
      cell_d.x = cell_i.x + (cell_i.y >>> SHIFT);
      cell_d.y = cell_i.y + (cell_i.x >>> SHIFT);
      cell_d.z = cell_i.z - ANG;
    end else begin
      cell_d.x = cell_i.x - (cell_i.y >>> SHIFT);
      cell_d.y = cell_i.y - (cell_i.x >>> SHIFT);
      cell_d.z = cell_i.z + ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/csec_mulq.sv
// three stage q.30 multiplier, sign-magnitude with truncation toward zero
// depends on csec_pkg
module csec_mulq (
  input  logic                           clk_i,
  input  logic signed [csec_pkg::PW-1:0] a_i,
  input  logic signed [csec_pkg::PW-1:0] b_i,
  output logic signed [csec_pkg::MW-1:0] p_o
);

  localparam int unsigned PW  = csec_pkg::PW;
  localparam int unsigned LOW = csec_pkg::LOW;
  localparam int unsigned MW  = csec_pkg::MW;

  logic [PW-1:0] ua_q, ub_q;
  logic          sg_q, sg2_q;
  logic [2*LOW-1:0]      ll_q;
  logic [PW-1:0]         hl_q, lh_q;
  logic [2*(PW-LOW)-1:0] hh_q;
  logic [MW-1:0]         mag_d;
  logic signed [MW-1:0]  p_q;

  always_ff @(posedge clk_i) begin
    ua_q <= a_i[PW-1] ? PW'(-a_i) : PW'(a_i);
    ub_q <= b_i[PW-1] ? PW'(-b_i) : PW'(b_i);
    sg_q <= a_i[PW-1] ^ b_i[PW-1];
  end

  // partial products of the split operands
  always_ff @(posedge clk_i) begin
    ll_q  <= ua_q[LOW-1:0] * ub_q[LOW-1:0];
    hl_q  <= ua_q[PW-1:LOW] * ub_q[LOW-1:0];
    lh_q  <= ua_q[LOW-1:0] * ub_q[PW-1:LOW];
    hh_q  <= ua_q[PW-1:LOW] * ub_q[PW-1:LOW];
    sg2_q <= sg_q;
  end

  assign mag_d = (MW'(hh_q) << LOW) + MW'(hl_q) + MW'(lh_q) + MW'(ll_q >> LOW);

  always_ff @(posedge clk_i) begin
    p_q <= sg2_q ? -$signed(mag_d) : $signed(mag_d);
  end

  assign p_o = p_q;

endmodule

// File: rtl/csec_div_cell.sv
// one restoring division step for the real and imaginary quotients
// depends on csec_pkg
module csec_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                clk_i,
  input  csec_pkg::csec_div_t cell_i,
  output csec_pkg::csec_div_t cell_o
);

  localparam int unsigned RW  = csec_pkg::RW;
  localparam int unsigned DCW = csec_pkg::DCW;

  csec_pkg::csec_div_t cell_d, cell_q;
  logic [DCW-1:0] den_w;

  assign den_w = DCW'(cell_i.den) << SHIFT;

  always_comb begin
    cell_d = cell_i;
    if (DCW'(cell_i.rem_re) >= den_w) begin
      cell_d.rem_re      = cell_i.rem_re - RW'(den_w);
      cell_d.q_re[SHIFT] = 1'b1;
    end
    if (DCW'(cell_i.rem_im) >= den_w) begin
      cell_d.rem_im      = cell_i.rem_im - RW'(den_w);
      cell_d.q_im[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/complex_secant_unit.sv
// complex secant unit: sec(a+bi) in signed q16.16 through cordic and divider cell rows
// depends on csec_pkg, csec_circ_cell, csec_hyp_cell, csec_mulq, csec_div_cell
//
//  channel   direction  handshake              payload
//  input     in         start / busy           data_i   (csec_in_t)
//  result    out        done_o, one-cycle      result_o (csec_out_t)
//
// one transaction per cycle; each passes through the range reduction steps, the cordic
// rows, the multipliers and the 32 divider cells.
// busy stays low, every cell hands its data on in every cycle.
// reset clears only the valid line; the payload registers need none.
// the receiver cannot stall, a result is shown for exactly one cycle.
module complex_secant_unit #(
  parameter int unsigned CORDIC_STAGES = csec_pkg::CORDIC_STAGES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  csec_pkg::csec_in_t  data_i,
  output logic                done_o,
  output csec_pkg::csec_out_t result_o
);

  localparam int unsigned N   = CORDIC_STAGES;
  localparam int unsigned DS  = csec_pkg::DIV_STEPS;
  localparam int unsigned LAT = N + 47;
  localparam int unsigned PW  = csec_pkg::PW;
  localparam int unsigned MW  = csec_pkg::MW;
  localparam int unsigned RW  = csec_pkg::RW;
  localparam int unsigned ZW  = csec_pkg::ZW;

  logic [LAT-1:0] vld_q;

  // input capture and range reduction
  logic [39:0] red_v_q [7];
  logic [33:0] red_m_q [7];
  logic [3:0]  red_k_q [7];
  logic        red_bneg_q [7];
  logic signed [23:0] b_clamp;
  logic [19:0]        b_mag;
  logic signed [40:0] v_init;

  always_comb begin
    if (data_i.imag_part > csec_pkg::B_LIMIT) begin
      b_clamp = csec_pkg::B_LIMIT;
    end else if (data_i.imag_part < -csec_pkg::B_LIMIT) begin
      b_clamp = -csec_pkg::B_LIMIT;
    end else begin
      b_clamp = data_i.imag_part;
    end
    b_mag  = b_clamp[23] ? 20'(-b_clamp) : 20'(b_clamp);
    v_init = $signed({{3{data_i.real_part[23]}}, data_i.real_part, 14'b0}) + csec_pkg::V_OFFSET;
  end

  always_ff @(posedge clk_i) begin
    red_v_q[0]    <= v_init[39:0];
    red_m_q[0]    <= {b_mag, 14'b0};
    red_k_q[0]    <= '0;
    red_bneg_q[0] <= b_clamp[23];
  end

  for (genvar t = 1; t <= 6; t++) begin : g_red
    localparam int unsigned K = 6 - t;
    localparam logic [39:0] VSTEP = csec_pkg::TWO_PI_Q << K;
    localparam logic [33:0] MSTEP = csec_pkg::LN2_Q << K;
    localparam logic [3:0]  KBIT  = 4'(1 << (K & 3));
    always_ff @(posedge clk_i) begin
      red_v_q[t] <= (red_v_q[t-1] >= VSTEP) ? red_v_q[t-1] - VSTEP : red_v_q[t-1];
      if ((K <= 3) && (red_m_q[t-1] >= MSTEP)) begin
        red_m_q[t] <= red_m_q[t-1] - MSTEP;
        red_k_q[t] <= red_k_q[t-1] | KBIT;
      end else begin
        red_m_q[t] <= red_m_q[t-1];
        red_k_q[t] <= red_k_q[t-1];
      end
      red_bneg_q[t] <= red_bneg_q[t-1];
    end
  end

  // fold into [-pi/2, pi/2] and load both cordic rows
  typedef struct packed {
    logic       neg;
    logic [3:0] k;
    logic       mzero;
    logic       bneg;
  } side_t;

  csec_pkg::csec_circ_t circ_s [N+1];
  csec_pkg::csec_hyp_t  hyp_s  [N+1];
  side_t                side_q [N+1];
  logic signed [40:0]   fold_r;
  logic signed [ZW-1:0] fold_ang;
  logic                 fold_neg;

  always_comb begin
    if (red_v_q[6] >= csec_pkg::PI_Q) begin
      fold_r = $signed({1'b0, red_v_q[6]}) - $signed({1'b0, csec_pkg::TWO_PI_Q});
    end else begin
      fold_r = $signed({1'b0, red_v_q[6]});
    end
    fold_neg = 1'b0;
    fold_ang = ZW'(fold_r);
    if (fold_r > $signed({1'b0, csec_pkg::HALF_PI_Q})) begin
      fold_ang = ZW'(fold_r - $signed({1'b0, csec_pkg::PI_Q}));
      fold_neg = 1'b1;
    end else if (fold_r < -$signed({1'b0, csec_pkg::HALF_PI_Q})) begin
      fold_ang = ZW'(fold_r + $signed({1'b0, csec_pkg::PI_Q}));
      fold_neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    circ_s[0].x  <= csec_pkg::CIRC_GAIN;
    circ_s[0].y  <= '0;
    circ_s[0].z  <= fold_ang;
    hyp_s[0].x   <= csec_pkg::HYP_GAIN;
    hyp_s[0].y   <= '0;
    hyp_s[0].z   <= $signed(ZW'(red_m_q[6]));
    side_q[0].neg   <= fold_neg;
    side_q[0].k     <= red_k_q[6];
    side_q[0].mzero <= (red_m_q[0+6] == '0) && (red_k_q[6] == '0);
    side_q[0].bneg  <= red_bneg_q[6];
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    csec_circ_cell #(.STAGE(i)) u_circ (
      .clk_i  (clk_i),
      .cell_i (circ_s[i]),
      .cell_o (circ_s[i+1])
    );
    csec_hyp_cell #(.STAGE(i)) u_hyp (
      .clk_i  (clk_i),
      .cell_i (hyp_s[i]),
      .cell_o (hyp_s[i+1])
    );
    always_ff @(posedge clk_i) begin
      side_q[i+1] <= side_q[i];
    end
  end

  // exponent scaling, sign fixups
  logic signed [PW-1:0] sc_ep, sc_em, sc_ch, sc_sh;
  logic signed [PW-1:0] sc_c_q, sc_s_q, sc_ch_q, sc_sh_q;

  always_comb begin
    sc_ep = (PW'(hyp_s[N].x) + PW'(hyp_s[N].y)) <<< side_q[N].k;
    sc_em = (PW'(hyp_s[N].x) - PW'(hyp_s[N].y)) >>> side_q[N].k;
    sc_ch = (sc_ep + sc_em) >>> 1;
    sc_sh = (sc_ep - sc_em) >>> 1;
    if (side_q[N].mzero) begin
      sc_ch = csec_pkg::ONE_Q;
      sc_sh = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_c_q  <= side_q[N].neg ? -PW'(circ_s[N].x) : PW'(circ_s[N].x);
    sc_s_q  <= side_q[N].neg ? -PW'(circ_s[N].y) : PW'(circ_s[N].y);
    sc_ch_q <= sc_ch;
    sc_sh_q <= side_q[N].bneg ? -sc_sh : sc_sh;
  end

  logic signed [MW-1:0] p_cc, p_shsh, p_cch, p_ssh;

  csec_mulq u_mul_cc   (.clk_i(clk_i), .a_i(sc_c_q),  .b_i(sc_c_q),  .p_o(p_cc));
  csec_mulq u_mul_shsh (.clk_i(clk_i), .a_i(sc_sh_q), .b_i(sc_sh_q), .p_o(p_shsh));
  csec_mulq u_mul_cch  (.clk_i(clk_i), .a_i(sc_c_q),  .b_i(sc_ch_q), .p_o(p_cch));
  csec_mulq u_mul_ssh  (.clk_i(clk_i), .a_i(sc_s_q),  .b_i(sc_sh_q), .p_o(p_ssh));

  // denominator and divider setup
  logic signed [MW-1:0] den_sum;
  logic [MW-1:0]        den_q;
  logic signed [MW-1:0] nre_q, nim_q;
  logic                 pole_q;
  logic [MW-1:0]        nmag_re, nmag_im;
  csec_pkg::csec_div_t  div_s [DS+1];

  assign den_sum = p_cc + p_shsh;

  always_ff @(posedge clk_i) begin
    den_q  <= MW'(den_sum);
    nre_q  <= p_cch;
    nim_q  <= p_ssh;
    pole_q <= (den_sum == '0);
  end

  assign nmag_re = nre_q[MW-1] ? MW'(-nre_q) : MW'(nre_q);
  assign nmag_im = nim_q[MW-1] ? MW'(-nim_q) : MW'(nim_q);

  // a quotient of 2^32 or more only ever saturates
  always_ff @(posedge clk_i) begin
    div_s[0].rem_re <= {nmag_re, 16'b0};
    div_s[0].rem_im <= {nmag_im, 16'b0};
    div_s[0].den    <= den_q;
    div_s[0].q_re   <= '0;
    div_s[0].q_im   <= '0;
    div_s[0].neg_re <= nre_q[MW-1];
    div_s[0].neg_im <= nim_q[MW-1];
    div_s[0].ovf_re <= RW'(nmag_re) >= {den_q, 16'b0};
    div_s[0].ovf_im <= RW'(nmag_im) >= {den_q, 16'b0};
    div_s[0].pole   <= pole_q;
  end

  for (genvar i = 0; i < DS; i++) begin : g_div
    csec_div_cell #(.SHIFT(DS - 1 - i)) u_div (
      .clk_i  (clk_i),
      .cell_i (div_s[i]),
      .cell_o (div_s[i+1])
    );
  end

  // saturation and result register
  csec_pkg::csec_out_t res_d, res_q;
  logic sat_re, sat_im;
  logic signed [31:0] val_re, val_im;

  always_comb begin
    if (!div_s[DS].neg_re) begin
      sat_re = div_s[DS].ovf_re || div_s[DS].q_re[31];
      val_re = sat_re ? 32'sh7FFFFFFF : $signed(div_s[DS].q_re);
    end else begin
      sat_re = div_s[DS].ovf_re || (div_s[DS].q_re > 32'h80000000);
      val_re = sat_re ? 32'sh80000000 : -$signed(div_s[DS].q_re);
    end
    if (!div_s[DS].neg_im) begin
      sat_im = div_s[DS].ovf_im || div_s[DS].q_im[31];
      val_im = sat_im ? 32'sh7FFFFFFF : $signed(div_s[DS].q_im);
    end else begin
      sat_im = div_s[DS].ovf_im || (div_s[DS].q_im > 32'h80000000);
      val_im = sat_im ? 32'sh80000000 : -$signed(div_s[DS].q_im);
    end
    if (div_s[DS].pole) begin
      res_d.real_result    = 32'sh7FFFFFFF;
      res_d.imag_result    = 32'sh7FFFFFFF;
      res_d.pole_flag      = 1'b1;
      res_d.saturated_flag = 1'b0;
    end else begin
      res_d.real_result    = val_re;
      res_d.imag_result    = val_im;
      res_d.pole_flag      = 1'b0;
      res_d.saturated_flag = sat_re || sat_im;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // transaction valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start & ~busy};
    end
  end

  assign busy     = 1'b0;
  assign done_o   = vld_q[LAT-1];
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without a transaction");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.pole_flag && result_o.saturated_flag))
    else $error("pole and saturation both set");

  a_pole_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.pole_flag) |->
      (result_o.real_result == 32'sh7FFFFFFF && result_o.imag_result == 32'sh7FFFFFFF))
    else $error("pole result not at maximum");
`endif

endmodule

// File: verif/tb_complex_secant_unit.sv
// self-checking testbench for complex_secant_unit: directed and random complex inputs,
// each result checked against a fixed-point secant predictor; depends on csec_pkg
module tb_complex_secant_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = csec_pkg::CORDIC_STAGES + 47;
  localparam int WD_LIMIT = 4 * LATENCY + 400;

  logic                clk;
  logic                rst_n;
  logic                start_r;
  logic                busy_w;
  csec_pkg::csec_in_t  data_r;
  logic                done_w;
  csec_pkg::csec_out_t result_w;

  csec_pkg::csec_out_t secant_q[$];
  int                  errors;
  int                  idle_cycles;

  complex_secant_unit u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start   (start_r),
    .busy    (busy_w),
    .data_i  (data_r),
    .done_o  (done_w),
    .result_o(result_w)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint atan_step(input int i);
    longint t [10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                       33543515, 16775850, 8388437, 4194282, 2097149};
    if (i < 10) return t[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  function automatic longint atanh_step(input int i);
    longint t [10] = '{0, 589812981, 274247419, 134923406, 67196451,
                       33565361, 16778581, 8388779, 4194325, 2097155};
    if (i < 10) return t[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  function automatic int num_stages();
    int n;
    n = csec_pkg::CORDIC_STAGES;
    if (n < 1) n = 1;
    if (n > 32) n = 32;
    return n;
  endfunction

  // q.30 product truncated toward zero
  function automatic longint mul_q30(input longint x, input longint y);
    longint unsigned u, v, m, r;
    u = (x < 0) ? -x : x;
    v = (y < 0) ? -y : y;
    m = (64'd1 << 30) - 1;
    r = (((u >> 30) * (v >> 30)) << 30) + (u >> 30) * (v & m) + (u & m) * (v >> 30)
        + (((u & m) * (v & m)) >> 30);
    return ((x < 0) != (y < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint div_clip(input longint num, input longint den, inout logic sat);
    longint unsigned mag, q;
    mag = (num < 0) ? -num : num;
    q   = (mag << 16) / longint'(den);
    if (num >= 0) begin
      if (q > 64'h7FFFFFFF) begin
        sat = 1'b1;
        return 64'h7FFFFFFF;
      end
      return longint'(q);
    end
    if (q > 64'h80000000) begin
      sat = 1'b1;
      return -longint'(64'h80000000);
    end
    return -longint'(q);
  endfunction

  function automatic csec_pkg::csec_out_t secant_of(input csec_pkg::csec_in_t in);
    longint              a, b, aq, rem, x, y, z, t, c, s, ch, sh, mag, k, ep, em, d, re, im;
    int                  n, i, j, rep;
    logic                neg, again, sat, pole;
    csec_pkg::csec_out_t r;
    n = num_stages();
    a = in.real_part;
    b = in.imag_part;
    if (b > 524288) b = 524288;
    if (b < -524288) b = -524288;
    sat  = 1'b0;
    pole = 1'b0;

    // range reduction to [-pi, pi), then fold to [-pi/2, pi/2]
    aq  = a * 16384;
    rem = aq - (aq / 64'sd6746518852) * 64'sd6746518852;
    if (rem < 0) rem += 64'sd6746518852;
    if (rem >= 64'sd3373259426) rem -= 64'sd6746518852;
    neg = 1'b0;
    if (rem > 64'sd1686629713) begin
      rem -= 64'sd3373259426;
      neg = 1'b1;
    end else if (rem < -64'sd1686629713) begin
      rem += 64'sd3373259426;
      neg = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = rem;
    for (i = 0; i < n; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_step(i);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_step(i);
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;

    // |b| = k*ln2 + r, hyperbolic rotation on r then scale by 2^k
    mag = ((b < 0) ? -b : b) * 16384;
    if (mag == 0) begin
      ch = 64'sd1 << 30;
      sh = 0;
    end else begin
      k = mag / 744261118;
      z = mag - k * 744261118;
      x = 889229343;
      y = 0;
      j = 1;
      rep = 4;
      again = 1'b0;
      for (i = 0; i < n; i++) begin
        if (z >= 0) begin
          t = x + (y >>> j); y = y + (x >>> j); x = t; z -= atanh_step(j);
        end else begin
          t = x - (y >>> j); y = y - (x >>> j); x = t; z += atanh_step(j);
        end
        if (j == rep && !again) begin
          again = 1'b1;
        end else begin
          if (again) begin
            again = 1'b0;
            rep = 3 * rep + 1;
          end
          j++;
        end
      end
      ep = (x + y) << k;
      em = (x - y) >>> k;
      ch = (ep + em) >>> 1;
      sh = (ep - em) >>> 1;
    end
    if (b < 0) sh = -sh;

    d = mul_q30(c, c) + mul_q30(sh, sh);
    if (d == 0) begin
      pole = 1'b1;
      re = 64'h7FFFFFFF;
      im = 64'h7FFFFFFF;
    end else begin
      re = div_clip(mul_q30(c, ch), d, sat);
      im = div_clip(mul_q30(s, sh), d, sat);
    end
    r.real_result    = re[31:0];
    r.imag_result    = im[31:0];
    r.pole_flag      = pole;
    r.saturated_flag = sat;
    return r;
  endfunction

  // ---------------- driving ----------------
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_number(input logic signed [23:0] re, input logic signed [23:0] im,
                             input int gap);
    csec_pkg::csec_in_t item;
    item.real_part = re;
    item.imag_part = im;
    if (gap > 0) begin
      @(negedge clk);
      start_r <= 1'b0;
      data_r  <= csec_pkg::csec_in_t'({24'($urandom), 24'($urandom)});
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start_r <= 1'b1;
    data_r  <= item;
    @(posedge clk);
    while (busy_w) @(posedge clk);
    secant_q.push_back(secant_of(item));
  endtask

  task automatic quiet_sender();
    @(negedge clk);
    start_r <= 1'b0;
  endtask

  task automatic wait_drained();
    quiet_sender();
    while (secant_q.size() != 0) @(posedge clk);
  endtask

  // ---------------- checking ----------------
  always @(posedge clk) begin
    if (rst_n && done_w) begin
      if (secant_q.size() == 0) begin
        $error("result with no transaction outstanding: %h", result_w);
        errors++;
      end else begin
        csec_pkg::csec_out_t e;
        e = secant_q.pop_front();
        if (result_w.real_result !== e.real_result) begin
          $error("real_result expected %0d actual %0d", e.real_result, result_w.real_result);
          errors++;
        end
        if (result_w.imag_result !== e.imag_result) begin
          $error("imag_result expected %0d actual %0d", e.imag_result, result_w.imag_result);
          errors++;
        end
        if (result_w.pole_flag !== e.pole_flag) begin
          $error("pole_flag expected %0b actual %0b", e.pole_flag, result_w.pole_flag);
          errors++;
        end
        if (result_w.saturated_flag !== e.saturated_flag) begin
          $error("saturated_flag expected %0b actual %0b", e.saturated_flag,
                 result_w.saturated_flag);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (start_r && !busy_w) || done_w) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_extremes();
    logic signed [23:0] v [5] = '{24'sh800000, 24'sh7FFFFF, 24'sd0, -24'sd1, 24'sd1};
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) send_number(v[i], v[j], 0);
    end
  endtask

  task automatic test_poles();
    // real part near +/- pi/2, 3pi/2, mostly no imaginary part: denominator vanishes
    send_number(24'sd102944, 24'sd0, 0);
    send_number(-24'sd102944, 24'sd0, 1);
    send_number(24'sd308831, 24'sd0, 0);
    send_number(24'sd102943, 24'sd1, 0);
    send_number(24'sd102944, 24'sd524288, 0);
    send_number(24'sd102944, -24'sd600000, 2);
  endtask

  task automatic test_random(input int count);
    logic signed [23:0] re, im;
    int p;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 9);
      case (p)
        0, 1, 2: begin
          re = 24'($urandom);
          im = 24'($urandom);
        end
        3, 4, 5: begin
          re = $signed(24'($urandom_range(0, 823550))) - 24'sd411775;
          im = $signed(24'($urandom_range(0, 262144))) - 24'sd131072;
        end
        6: begin
          re = $signed(24'($urandom_range(102900, 102990)));
          if ($urandom_range(0, 1)) re = -re;
          im = $signed(24'($urandom_range(0, 8))) - 24'sd4;
        end
        7: begin
          re = 24'($urandom);
          im = 24'sd0;
        end
        default: begin
          re = $signed(24'($urandom_range(0, 65536))) - 24'sd32768;
          im = $urandom_range(0, 1) ? 24'sd524288 + 24'($urandom_range(0, 7000000))
                                     : -24'sd524288 - 24'($urandom_range(0, 7000000));
        end
      endcase
      send_number(re, im, gap_len());
      if (n % 100 == 50) wait_drained();
    end
  endtask

  initial begin
    errors      = 0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    start_r     = 1'b0;
    data_r      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_poles();
    wait_drained();
    test_random(480);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    if (errors == 0 && secant_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
